// File: design/sacf_pkg.sv
`timescale 1ns / 1ps

package sacf_pkg;

   // default sizes for the top level parameters
   localparam int DEF_MAX_WAYS  = 8;
   localparam int DEF_MAX_SETS  = 1024;
   localparam int DEF_ADDR_BITS = 48;

   // register field widths
   localparam int OFFSET_W = 4;
   localparam int SETB_W   = 4;
   localparam int WAYS_W   = 4;
   localparam int CNT_W    = 32;

   // csr channel
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 4;

   localparam logic [CSR_INDEX_W-1:0] CSR_OFFSET_BITS     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SET_BITS        = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_WAYS_IN_USE     = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PREFETCH_ENABLE = 2'd3;

   localparam logic [OFFSET_W-1:0] RST_OFFSET_BITS = 4'd6;
   localparam logic [SETB_W-1:0]   RST_SET_BITS    = 4'd4;
   localparam logic [WAYS_W-1:0]   RST_WAYS_IN_USE = 4'd1;
   localparam logic                RST_PREFETCH    = 1'b0;

   // access kind in req_tuser
   localparam logic REQ_READ  = 1'b0;
   localparam logic REQ_WRITE = 1'b1;

   // result word: three flags then four totals, padded to bytes
   localparam int RSP_FIELDS_W = 3 + 4 * CNT_W;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   typedef struct packed {
      logic done;        // one-cycle pulse, scan finished
      logic hit;         // valid line with matching tag seen
      logic free_found;  // an invalid way was seen before the end
   } scan_stat_type;

   function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] cnt,
                                                 input logic [1:0]       inc);
      logic [CNT_W:0] sum;
      sum = {1'b0, cnt} + (CNT_W + 1)'(inc);
      return sum[CNT_W] ? {CNT_W{1'b1}} : sum[CNT_W-1:0];
   endfunction

endpackage

// File: design/sacf_ram.sv
`timescale 1ns / 1ps

module sacf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/sacf_split.sv
`timescale 1ns / 1ps

module sacf_split #(
   parameter int MAX_SETS  = sacf_pkg::DEF_MAX_SETS,
   parameter int ADDR_BITS = sacf_pkg::DEF_ADDR_BITS,
   localparam int SET_W    = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1,
   localparam int SET_LIM  = $clog2(MAX_SETS + 1) - 1
) (
   input  logic [ADDR_BITS-1:0]         address,
   input  logic [sacf_pkg::OFFSET_W-1:0] offset_bits,
   input  logic [sacf_pkg::SETB_W-1:0]   set_bits,
   output logic [SET_W-1:0]             set_idx,
   output logic [ADDR_BITS-1:0]         tag
);

   logic [sacf_pkg::SETB_W-1:0] sb;
   logic [ADDR_BITS-1:0]        line_id;
   logic [SET_W-1:0]            set_mask;

   always_comb begin
      // set field width saturates at what the set store can hold
      if (int'(set_bits) > SET_LIM) begin
         sb = sacf_pkg::SETB_W'(SET_LIM);
      end else begin
         sb = set_bits;
      end
      line_id  = address >> offset_bits;
      set_mask = ~({SET_W{1'b1}} << sb);
      set_idx  = line_id[SET_W-1:0] & set_mask;
      tag      = line_id >> sb;
   end

endmodule

// File: design/sacf_way_scan.sv
`timescale 1ns / 1ps

module sacf_way_scan #(
   parameter int MAX_WAYS  = sacf_pkg::DEF_MAX_WAYS,
   parameter int ADDR_BITS = sacf_pkg::DEF_ADDR_BITS,
   localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1,
   localparam int WCNT_W   = $clog2(MAX_WAYS + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [WCNT_W-1:0]             ways_eff,
   input  logic [ADDR_BITS-1:0]          tag,
   input  logic [MAX_WAYS-1:0]           line_valid,
   input  logic [MAX_WAYS*ADDR_BITS-1:0] line_tags,
   output sacf_pkg::scan_stat_type       stat,
   output logic [WAY_W-1:0]              free_way
);

   logic             active_ff;
   logic             done_ff;
   logic             hit_ff;
   logic             free_found_ff;
   logic [WAY_W-1:0] free_way_ff;
   logic [WAY_W-1:0] idx_ff;

   logic                 entry_valid;
   logic [ADDR_BITS-1:0] entry_tag;
   logic                 match;
   logic                 last;

   // one way per cycle through the single tag comparator
   always_comb begin
      entry_valid = line_valid[idx_ff];
      entry_tag   = line_tags[idx_ff*ADDR_BITS +: ADDR_BITS];
      match       = entry_valid && (entry_tag == tag);
      last        = (WCNT_W'(idx_ff) + WCNT_W'(1)) == ways_eff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         done_ff <= active_ff && (match || last);
         if (start) begin
            active_ff <= 1'b1;
         end else if (active_ff && (match || last)) begin
            active_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         idx_ff        <= '0;
         hit_ff        <= 1'b0;
         free_found_ff <= 1'b0;
      end else if (active_ff) begin
         hit_ff <= match;
         if (!entry_valid && !free_found_ff) begin
            free_found_ff <= 1'b1;
            free_way_ff   <= idx_ff;
         end
         if (!(match || last)) begin
            idx_ff <= idx_ff + 1'b1;
         end
      end
   end

   assign stat.done       = done_ff;
   assign stat.hit        = hit_ff;
   assign stat.free_found = free_found_ff;
   assign free_way        = free_way_ff;

endmodule

// File: design/set_assoc_cache_fifo_prefetch.sv
`timescale 1ns / 1ps

// Set-associative tag cache with per-set FIFO replacement and optional
// next-line prefetch. Each request word (address, read/write kind) returns
// one response word: hit, demand fill, prefetch fill and four saturating
// totals. One access is worked at a time; req_tready is high only when the
// sequencer is idle. A set lookup reads one row of the tag memory (all ways,
// valid bits and FIFO pointer) and then walks the ways through one shared
// tag comparator, one way per cycle, stopping at the first match. A miss
// adds a row write, and the response word is registered last. With prefetch
// on, a demand miss is followed by a lookup of the next line, which is
// filled if it misses. After reset the block sweeps the tag memory clearing
// valid bits and FIFO pointers, one set per cycle, before the first request
// is accepted. CSR writes are taken at any time and do not flush the cache.
module set_assoc_cache_fifo_prefetch #(
   parameter int MAX_WAYS     = sacf_pkg::DEF_MAX_WAYS,
   parameter int MAX_SETS     = sacf_pkg::DEF_MAX_SETS,
   parameter int ADDR_BITS    = sacf_pkg::DEF_ADDR_BITS,
   localparam int REQ_DATA_W  = ((ADDR_BITS + 7) / 8) * 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request: tdata = address; tuser = req_type (0 read, 1 write)
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [REQ_DATA_W-1:0]                 req_tdata,
   input  logic                                  req_tuser,
   // response tdata, from bit 0: hit, demand_fill, prefetch_fill,
   // hit_count[32], miss_count[32], read_count[32], write_count[32]
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [sacf_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   // csr write channel
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [sacf_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [sacf_pkg::CSR_DATA_W-1:0]       csr_data
);

   localparam int WAY_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int WCNT_W  = $clog2(MAX_WAYS + 1);
   localparam int SET_W   = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
   // tag row: tags of all ways, then valid bits, then FIFO pointer
   localparam int TAGS_W  = MAX_WAYS * ADDR_BITS;
   localparam int VLD_LSB = TAGS_W;
   localparam int PTR_LSB = TAGS_W + MAX_WAYS;
   localparam int ROW_W   = PTR_LSB + WAY_W;
   localparam int CNT_W   = sacf_pkg::CNT_W;
   localparam int PAD_W   = sacf_pkg::RSP_DATA_W - sacf_pkg::RSP_FIELDS_W;

   typedef enum logic [5:0] {
      ST_CLEAR  = 6'b000001,
      ST_IDLE   = 6'b000010,
      ST_LOOK   = 6'b000100,
      ST_SCAN   = 6'b001000,
      ST_FILL   = 6'b010000,
      ST_FINISH = 6'b100000
   } state_type;

   state_type state_ff;
   state_type state_in;

   // configuration
   logic [sacf_pkg::OFFSET_W-1:0] offset_ff;
   logic [sacf_pkg::SETB_W-1:0]   set_bits_ff;
   logic [sacf_pkg::WAYS_W-1:0]   ways_ff;
   logic                          prefetch_ff;

   // access in flight
   logic [ADDR_BITS-1:0] addr_ff;
   logic                 kind_ff;
   logic                 phase_ff;   // 0 demand lookup, 1 next-line lookup
   logic [SET_W-1:0]     set_ff;
   logic [ADDR_BITS-1:0] tag_ff;
   logic                 dhit_ff;
   logic                 pf_ff;
   logic [SET_W-1:0]     clr_ff;

   // totals
   logic [CNT_W-1:0] hits_ff;
   logic [CNT_W-1:0] misses_ff;
   logic [CNT_W-1:0] reads_ff;
   logic [CNT_W-1:0] writes_ff;
   logic [CNT_W-1:0] hits_in;
   logic [CNT_W-1:0] misses_in;
   logic [CNT_W-1:0] reads_in;
   logic [CNT_W-1:0] writes_in;

   logic                            rsp_valid_ff;
   logic [sacf_pkg::RSP_DATA_W-1:0] rsp_data_ff;

   logic [WCNT_W-1:0]    ways_eff;
   logic [SET_W-1:0]     split_set;
   logic [ADDR_BITS-1:0] split_tag;
   logic [ADDR_BITS-1:0] line_size;

   logic             ram_wr_en;
   logic [SET_W-1:0] ram_wr_addr;
   logic [ROW_W-1:0] ram_wr_data;
   logic             ram_rd_en;
   logic [ROW_W-1:0] ram_rd_data;

   sacf_pkg::scan_stat_type scan_stat;
   logic [WAY_W-1:0]        scan_free_way;

   logic [WAY_W-1:0] ptr_old;
   logic [WAY_W-1:0] ptr_use;
   logic [WAY_W-1:0] ptr_next;
   logic [WAY_W-1:0] victim;
   logic [ROW_W-1:0] new_row;
   logic             out_free;

   // ways_in_use of zero acts as one; large values clamp
   always_comb begin
      if (ways_ff == '0) begin
         ways_eff = WCNT_W'(1);
      end else if (int'(ways_ff) > MAX_WAYS) begin
         ways_eff = WCNT_W'(MAX_WAYS);
      end else begin
         ways_eff = WCNT_W'(ways_ff);
      end
   end

   // address split; shared by the demand and next-line lookups
   sacf_split #(
      .MAX_SETS  (MAX_SETS),
      .ADDR_BITS (ADDR_BITS)
   ) u_split (
      .address     (addr_ff),
      .offset_bits (offset_ff),
      .set_bits    (set_bits_ff),
      .set_idx     (split_set),
      .tag         (split_tag)
   );

   assign line_size = ADDR_BITS'(1) << offset_ff;

   sacf_ram #(
      .WIDTH (ROW_W),
      .DEPTH (MAX_SETS)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (split_set),
      .rd_data (ram_rd_data)
   );

   sacf_way_scan #(
      .MAX_WAYS  (MAX_WAYS),
      .ADDR_BITS (ADDR_BITS)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .start      (state_ff == ST_LOOK),
      .ways_eff   (ways_eff),
      .tag        (tag_ff),
      .line_valid (ram_rd_data[VLD_LSB +: MAX_WAYS]),
      .line_tags  (ram_rd_data[TAGS_W-1:0]),
      .stat       (scan_stat),
      .free_way   (scan_free_way)
   );

   // fill: first invalid way, else the FIFO victim; a stale pointer
   // (not below the ways in use) falls back to way 0
   always_comb begin
      ptr_old = ram_rd_data[PTR_LSB +: WAY_W];
      if (WCNT_W'(ptr_old) >= ways_eff) begin
         ptr_use = '0;
      end else begin
         ptr_use = ptr_old;
      end
      if ((WCNT_W'(ptr_use) + WCNT_W'(1)) == ways_eff) begin
         ptr_next = '0;
      end else begin
         ptr_next = ptr_use + 1'b1;
      end
      victim  = scan_stat.free_found ? scan_free_way : ptr_use;
      new_row = ram_rd_data;
      new_row[VLD_LSB + int'(victim)]         = 1'b1;
      new_row[victim*ADDR_BITS +: ADDR_BITS]  = tag_ff;
      if (!scan_stat.free_found) begin
         new_row[PTR_LSB +: WAY_W] = ptr_next;
      end
   end

   assign ram_rd_en   = (state_ff == ST_LOOK);
   assign ram_wr_en   = (state_ff == ST_CLEAR) || (state_ff == ST_FILL);
   assign ram_wr_addr = (state_ff == ST_CLEAR) ? clr_ff : set_ff;
   assign ram_wr_data = (state_ff == ST_CLEAR) ? '0 : new_row;

   assign out_free = !rsp_valid_ff || rsp_tready;

   // totals after this access
   always_comb begin
      hits_in   = hits_ff;
      misses_in = misses_ff;
      reads_in  = reads_ff;
      if (dhit_ff) begin
         hits_in = sacf_pkg::sat_add(hits_ff, 2'd1);
      end else begin
         misses_in = sacf_pkg::sat_add(misses_ff, 2'd1);
         reads_in  = sacf_pkg::sat_add(reads_ff, pf_ff ? 2'd2 : 2'd1);
      end
      writes_in = (kind_ff == sacf_pkg::REQ_WRITE) ?
                  sacf_pkg::sat_add(writes_ff, 2'd1) : writes_ff;
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == SET_W'(MAX_SETS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (scan_stat.done) begin
               state_in = scan_stat.hit ? ST_FINISH : ST_FILL;
            end
         end
         ST_FILL: begin
            state_in = (!phase_ff && prefetch_ff) ? ST_LOOK : ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         offset_ff    <= sacf_pkg::RST_OFFSET_BITS;
         set_bits_ff  <= sacf_pkg::RST_SET_BITS;
         ways_ff      <= sacf_pkg::RST_WAYS_IN_USE;
         prefetch_ff  <= sacf_pkg::RST_PREFETCH;
         hits_ff      <= '0;
         misses_ff    <= '0;
         reads_ff     <= '0;
         writes_ff    <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) begin
            clr_ff <= clr_ff + 1'b1;
         end
         if (csr_valid) begin
            unique case (csr_index)
               sacf_pkg::CSR_OFFSET_BITS:     offset_ff   <= csr_data;
               sacf_pkg::CSR_SET_BITS:        set_bits_ff <= csr_data;
               sacf_pkg::CSR_WAYS_IN_USE:     ways_ff     <= csr_data;
               sacf_pkg::CSR_PREFETCH_ENABLE: prefetch_ff <= csr_data[0];
               default: ;
            endcase
         end
         // a new word may replace the one leaving in the same cycle
         if ((state_ff == ST_FINISH) && out_free) begin
            rsp_valid_ff <= 1'b1;
            hits_ff      <= hits_in;
            misses_ff    <= misses_in;
            reads_ff     <= reads_in;
            writes_ff    <= writes_in;
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // access payload
   always_ff @(posedge clock) begin
      if ((state_ff == ST_IDLE) && req_tvalid) begin
         addr_ff  <= req_tdata[ADDR_BITS-1:0];
         kind_ff  <= req_tuser;
         phase_ff <= 1'b0;
         pf_ff    <= 1'b0;
      end
      if (state_ff == ST_LOOK) begin
         set_ff <= split_set;
         tag_ff <= split_tag;
      end
      if ((state_ff == ST_SCAN) && scan_stat.done && !phase_ff) begin
         dhit_ff <= scan_stat.hit;
      end
      if (state_ff == ST_FILL) begin
         if (phase_ff) begin
            pf_ff <= 1'b1;
         end else if (prefetch_ff) begin
            // next line, wrapped to the address width
            addr_ff  <= addr_ff + line_size;
            phase_ff <= 1'b1;
         end
      end
      if ((state_ff == ST_FINISH) && out_free) begin
         rsp_data_ff <= {PAD_W'(0), writes_in, reads_in, misses_in, hits_in,
                         pf_ff, !dhit_ff, dhit_ff};
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_ready  = 1'b1;

`ifndef ASSERT_OFF
   // scan results only arrive while the sequencer waits for them
   a_scan_done_in_scan: assert property (@(posedge clock) disable iff (reset)
      scan_stat.done |-> (state_ff == ST_SCAN))
      else $error("way scan finished outside the scan state");

   // a prefetch fill is only reported together with a demand miss
   a_pf_after_miss: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff[2]) |-> (rsp_data_ff[1] && !rsp_data_ff[0]))
      else $error("prefetch fill reported on a demand hit");

   // hit and read totals never go down
   a_totals_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> ((hits_ff >= $past(hits_ff)) && (reads_ff >= $past(reads_ff))))
      else $error("saturating total decreased");
`endif

endmodule

// File: dv/sacf_access_checker.sv
`timescale 1ns / 1ps

// Watches the csr, request and response channels of the cache, keeps its own
// copy of the tag store and totals, and checks every response word in order.
module sacf_access_checker #(
   parameter int MAX_WAYS  = sacf_pkg::DEF_MAX_WAYS,
   parameter int MAX_SETS  = sacf_pkg::DEF_MAX_SETS,
   parameter int ADDR_BITS = sacf_pkg::DEF_ADDR_BITS,
   localparam int REQ_W    = ((ADDR_BITS + 7) / 8) * 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   input  logic                               req_tready,
   input  logic [REQ_W-1:0]                   req_tdata,
   input  logic                               req_tuser,
   input  logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic [sacf_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                               csr_valid,
   input  logic                               csr_ready,
   input  logic [sacf_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [sacf_pkg::CSR_DATA_W-1:0]    csr_data,
   output int                                 pending,
   output int                                 fail_count
);
   import sacf_pkg::*;

   // floor(log2(MAX_SETS)): widest set index the tag store can hold
   localparam int SET_LIMIT = $clog2(MAX_SETS + 1) - 1;

   typedef struct packed {
      logic        hit;
      logic        demand_fill;
      logic        prefetch_fill;
      logic [31:0] hits;
      logic [31:0] misses;
      logic [31:0] reads;
      logic [31:0] writes;
   } access_outcome_type;

   logic [3:0]           cfg_offset_bits;
   logic [3:0]           cfg_set_bits;
   logic [3:0]           cfg_ways;
   logic                 cfg_prefetch;

   logic                 line_valid_m [MAX_SETS * MAX_WAYS];
   logic [ADDR_BITS-1:0] line_tag_m   [MAX_SETS * MAX_WAYS];
   int unsigned          fifo_ptr     [MAX_SETS];
   logic [31:0]          hits_total, misses_total, reads_total, writes_total;

   access_outcome_type   outcome_q [$];
   int                   fails = 0;

   function automatic logic [31:0] bump(input logic [31:0] c);
      return (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
   endfunction

   function automatic int unsigned active_ways();
      if (cfg_ways == 0)
         return 1;
      return (cfg_ways > MAX_WAYS) ? MAX_WAYS : cfg_ways;
   endfunction

   function automatic void locate(input  logic [ADDR_BITS-1:0] a,
                                  output int unsigned          set_idx,
                                  output logic [ADDR_BITS-1:0] tag);
      int unsigned          sb;
      logic [ADDR_BITS-1:0] line_id;
      sb      = (cfg_set_bits > SET_LIMIT) ? SET_LIMIT : cfg_set_bits;
      line_id = a >> cfg_offset_bits;
      set_idx = int'(line_id) & ((1 << sb) - 1);
      tag     = line_id >> sb;
   endfunction

   function automatic logic present(input int unsigned set_idx,
                                    input logic [ADDR_BITS-1:0] tag);
      int unsigned e;
      for (int unsigned w = 0; w < active_ways(); w++) begin
         e = set_idx * MAX_WAYS + w;
         if (line_valid_m[e] && line_tag_m[e] == tag)
            return 1'b1;
      end
      return 1'b0;
   endfunction

   // first empty way, else the way the set's fifo pointer names
   function automatic void install(input int unsigned set_idx,
                                   input logic [ADDR_BITS-1:0] tag);
      int unsigned n, e, p;
      n = active_ways();
      for (int unsigned w = 0; w < n; w++) begin
         e = set_idx * MAX_WAYS + w;
         if (!line_valid_m[e]) begin
            line_valid_m[e] = 1'b1;
            line_tag_m[e]   = tag;
            return;
         end
      end
      p = fifo_ptr[set_idx];
      if (p >= n)
         p = 0;
      line_valid_m[set_idx * MAX_WAYS + p] = 1'b1;
      line_tag_m[set_idx * MAX_WAYS + p]   = tag;
      fifo_ptr[set_idx] = (p + 1) % n;
   endfunction

   function automatic access_outcome_type predict_access(input logic kind,
                                                         input logic [ADDR_BITS-1:0] a);
      access_outcome_type   o;
      int unsigned          set_idx;
      logic [ADDR_BITS-1:0] tag;
      logic [ADDR_BITS-1:0] next_addr;
      o = '0;
      locate(a, set_idx, tag);
      o.hit = present(set_idx, tag);
      if (o.hit) begin
         hits_total = bump(hits_total);
      end else begin
         misses_total = bump(misses_total);
         reads_total  = bump(reads_total);
         install(set_idx, tag);
         if (cfg_prefetch) begin
            next_addr = a + (ADDR_BITS'(1) << cfg_offset_bits);
            locate(next_addr, set_idx, tag);
            if (!present(set_idx, tag)) begin
               reads_total = bump(reads_total);
               install(set_idx, tag);
               o.prefetch_fill = 1'b1;
            end
         end
      end
      o.demand_fill = !o.hit;
      if (kind == REQ_WRITE)
         writes_total = bump(writes_total);
      o.hits   = hits_total;
      o.misses = misses_total;
      o.reads  = reads_total;
      o.writes = writes_total;
      return o;
   endfunction

   function automatic int field_bad(input string name, input logic [31:0] want,
                                    input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin
      access_outcome_type want, got;
      if (reset) begin
         cfg_offset_bits = RST_OFFSET_BITS;
         cfg_set_bits    = RST_SET_BITS;
         cfg_ways        = RST_WAYS_IN_USE;
         cfg_prefetch    = RST_PREFETCH;
         for (int e = 0; e < MAX_SETS * MAX_WAYS; e++)
            line_valid_m[e] = 1'b0;
         for (int s = 0; s < MAX_SETS; s++)
            fifo_ptr[s] = 0;
         hits_total   = '0;
         misses_total = '0;
         reads_total  = '0;
         writes_total = '0;
         outcome_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_OFFSET_BITS:     cfg_offset_bits = csr_data;
               CSR_SET_BITS:        cfg_set_bits    = csr_data;
               CSR_WAYS_IN_USE:     cfg_ways        = csr_data;
               CSR_PREFETCH_ENABLE: cfg_prefetch    = csr_data[0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            outcome_q.push_back(predict_access(req_tuser, req_tdata[ADDR_BITS-1:0]));
         if (rsp_tvalid && rsp_tready) begin
            got.hit           = rsp_tdata[0];
            got.demand_fill   = rsp_tdata[1];
            got.prefetch_fill = rsp_tdata[2];
            got.hits          = rsp_tdata[3 +: 32];
            got.misses        = rsp_tdata[35 +: 32];
            got.reads         = rsp_tdata[67 +: 32];
            got.writes        = rsp_tdata[99 +: 32];
            if (outcome_q.size() == 0) begin
               $error("response word with no access outstanding");
               fails++;
            end else begin
               want = outcome_q.pop_front();
               fails += field_bad("hit", want.hit, got.hit);
               fails += field_bad("demand_fill", want.demand_fill, got.demand_fill);
               fails += field_bad("prefetch_fill", want.prefetch_fill, got.prefetch_fill);
               fails += field_bad("hit_count", want.hits, got.hits);
               fails += field_bad("miss_count", want.misses, got.misses);
               fails += field_bad("read_count", want.reads, got.reads);
               fails += field_bad("write_count", want.writes, got.writes);
            end
         end
      end
      pending    <= outcome_q.size();
      fail_count <= fails;
   end

endmodule

// File: dv/set_assoc_cache_fifo_prefetch_test.sv
`timescale 1ns / 1ps

module set_assoc_cache_fifo_prefetch_test;
   import sacf_pkg::*;

   localparam int ADDR_W    = DEF_ADDR_BITS;
   localparam int REQ_W     = ((ADDR_W + 7) / 8) * 8;
   localparam int SET_LIMIT = $clog2(DEF_MAX_SETS + 1) - 1;
   localparam int POOL_N    = 24;
   localparam int PHASES    = 8;
   localparam int PHASE_LEN = 85;

   logic                        clock      = 1'b0;
   logic                        reset      = 1'b1;
   logic                        req_tvalid = 1'b0;
   logic                        req_tready;
   logic [REQ_W-1:0]            req_tdata  = '0;   // address
   logic                        req_tuser  = REQ_READ;  // req_type
   logic                        rsp_tvalid;
   logic                        rsp_tready = 1'b0;
   // from bit 0: hit, demand_fill, prefetch_fill, hit/miss/read/write counts
   logic [RSP_DATA_W-1:0]       rsp_tdata;
   logic                        csr_valid  = 1'b0;
   logic                        csr_ready;
   logic [CSR_INDEX_W-1:0]      csr_index  = CSR_OFFSET_BITS;
   logic [CSR_DATA_W-1:0]       csr_data   = '0;

   int                          pending;
   int                          fail_count;

   // idle knobs, percent per cycle
   int                          send_gap_pct = 0;
   int                          stall_pct    = 0;

   // current split, mirrored here to aim addresses at sets and neighbors
   logic [3:0]                  cur_offset = RST_OFFSET_BITS;
   logic [3:0]                  cur_sets   = RST_SET_BITS;
   logic [ADDR_W-1:0]           addr_pool [POOL_N];
   int                          words_sent    = 0;
   int                          settings_used = 1;

   always #2 clock = ~clock;

   set_assoc_cache_fifo_prefetch #(
      .MAX_WAYS  (DEF_MAX_WAYS),
      .MAX_SETS  (DEF_MAX_SETS),
      .ADDR_BITS (DEF_ADDR_BITS)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   sacf_access_checker #(
      .MAX_WAYS  (DEF_MAX_WAYS),
      .MAX_SETS  (DEF_MAX_SETS),
      .ADDR_BITS (DEF_ADDR_BITS)
   ) u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .pending    (pending),
      .fail_count (fail_count)
   );

   // receiver back-pressure, redrawn every cycle
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // one request word; valid stays high after the handshake so the next
   // word can follow back to back, callers drop it when they pause
   task automatic push_access(input logic kind, input logic [ADDR_W-1:0] a);
      while ($urandom_range(99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_W'(a);
      req_tuser  <= kind;
      do @(posedge clock); while (!req_tready);
      words_sent++;
   endtask

   // hold off until every response is in, then let the sequencer settle
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (30) @(posedge clock);
   endtask

   // rewrite all four registers with the cache idle
   task automatic apply_setting(input logic [3:0] off, input logic [3:0] sb,
                                input logic [3:0] ways, input logic pf);
      logic [CSR_INDEX_W-1:0] idx [4];
      logic [CSR_DATA_W-1:0]  val [4];
      idx = '{CSR_OFFSET_BITS, CSR_SET_BITS, CSR_WAYS_IN_USE, CSR_PREFETCH_ENABLE};
      val = '{off, sb, ways, {3'b000, pf}};
      wait_drained();
      for (int i = 0; i < 4; i++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[i];
         csr_data  <= val[i];
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid  <= 1'b0;
      cur_offset  = off;
      cur_sets    = sb;
      settings_used++;
   endtask

   // mostly reuse of a small working set: repeats hit, neighbor lines land
   // on prefetched lines, tag flips above the set field force conflicts in
   // one set; the rest is fully random noise
   function automatic logic [ADDR_W-1:0] pick_address();
      int                r, i;
      int unsigned       sb;
      logic [ADDR_W-1:0] a;
      r  = $urandom_range(99);
      i  = $urandom_range(POOL_N - 1);
      sb = (cur_sets > SET_LIMIT) ? SET_LIMIT : cur_sets;
      if (r < 55)
         a = addr_pool[i];
      else if (r < 70)
         a = addr_pool[i] + (ADDR_W'($urandom_range(1, 3)) << cur_offset);
      else if (r < 85)
         a = addr_pool[i] ^ (ADDR_W'($urandom_range(1, 7)) << (cur_offset + sb));
      else
         a = ADDR_W'({$urandom, $urandom});
      return a;
   endfunction

   initial begin
      logic [3:0] off, sb, ways;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // --- directed, no idling ---
      // reset split: 64 B lines, 16 sets, direct mapped, no prefetch
      push_access(REQ_READ,  48'h0);                // cold miss
      push_access(REQ_READ,  48'h0);                // hit
      push_access(REQ_WRITE, 48'h3F);               // same line, write hit
      push_access(REQ_WRITE, 48'hFFFF_FFFF_FFFF);   // top of address space
      push_access(REQ_READ,  48'hFFFF_FFFF_FFFF);
      push_access(REQ_READ,  48'h400);              // same set, new tag: evict
      push_access(REQ_READ,  48'h0);                // evicted line misses again

      // largest offset, set bits past the limit, ways zero acts as one;
      // next line of the top address wraps to line zero (old lines alias)
      apply_setting(4'd15, 4'd15, 4'd0, 1'b1);
      push_access(REQ_READ,  48'hFFFF_FFFF_FFFF);
      push_access(REQ_READ,  48'h7FFF);
      push_access(REQ_WRITE, 48'h8000);

      // byte lines, one set, ways above the maximum: fill all eight ways,
      // then let the fifo pointer walk through them
      apply_setting(4'd0, 4'd0, 4'd15, 1'b1);
      push_access(REQ_READ,  48'd0);
      push_access(REQ_READ,  48'd2);
      push_access(REQ_READ,  48'd4);
      push_access(REQ_READ,  48'd6);
      push_access(REQ_READ,  48'd8);
      push_access(REQ_WRITE, 48'd0);
      push_access(REQ_READ,  48'd1);

      // shrink to two ways with the fill pointer left past them
      apply_setting(4'd0, 4'd0, 4'd2, 1'b0);
      push_access(REQ_READ,  48'd100);
      push_access(REQ_READ,  48'd101);
      push_access(REQ_READ,  48'd100);
      push_access(REQ_WRITE, 48'hAAAA_AAAA_AAAA);
      push_access(REQ_READ,  48'h5555_5555_5555);

      // --- random phases, each with its own setting and idle pattern ---
      for (int p = 0; p < PHASES; p++) begin
         case ($urandom_range(3))
            0:       off = 4'd0;
            1:       off = 4'd15;
            2:       off = RST_OFFSET_BITS;
            default: off = 4'($urandom_range(15));
         endcase
         case ($urandom_range(3))
            0:       sb = 4'd0;
            1:       sb = 4'd15;
            default: sb = 4'($urandom_range(15));
         endcase
         case ($urandom_range(3))
            0:       ways = 4'd1;
            1:       ways = 4'd8;
            default: ways = 4'($urandom_range(15));
         endcase
         apply_setting(off, sb, ways, 1'($urandom_range(1)));

         case (p % 4)
            0: begin send_gap_pct = 0;  stall_pct = 0;  end
            1: begin send_gap_pct = 46; stall_pct = 0;  end
            2: begin send_gap_pct = 0;  stall_pct = 46; end
            default: begin send_gap_pct = 24; stall_pct = 24; end
         endcase

         // half the working set near zero, half anywhere
         for (int i = 0; i < POOL_N; i++)
            addr_pool[i] = (i % 2) ? ADDR_W'({$urandom, $urandom})
                                   : ADDR_W'($urandom_range(0, 65535));

         for (int n = 0; n < PHASE_LEN; n++) begin
            // drain mid-phase so the sequencer restarts from empty
            if (n == PHASE_LEN / 2)
               wait_drained();
            push_access($urandom_range(1) ? REQ_WRITE : REQ_READ, pick_address());
         end
      end

      send_gap_pct = 0;
      stall_pct    = 0;
      wait_drained();

      $display("Covered %0d access words over %0d cache settings, with sender gaps,",
               words_sent, settings_used);
      $display("receiver stalls, fifo eviction, prefetch wrap and stale fill pointers.");
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // watchdog: far beyond the slowest legal run, reset sweep included
   initial begin
      #2_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
